@@ rtl/rehs_pkg.sv @@
// ----------------------------------------------------------------------------
// Ring exclusion hop step package
// Transfer payload types, configuration register types, function and status
// codes and the fixed widths and constants shared by the ring stepper.
// ----------------------------------------------------------------------------
package rehs_pkg;

   // Fixed field widths of the transfer payloads.
   localparam int FUNC_W         = 2;
   localparam int PIDX_W         = 7;
   localparam int SITE_FIELD_W   = 7;
   localparam int RANDOM_W       = 16;
   localparam int STATUS_W       = 3;
   localparam int FLUX_W         = 32;
   localparam int COUNT_W        = 8;
   localparam int THRESHOLD_W    = 17;

   // Particle table depth follows from the particle index width.
   localparam int MAX_PARTICLES  = 2 ** PIDX_W;

   // Configuration port shape.
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = THRESHOLD_W;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTICLE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOP_THRESHOLD  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_SITE     = 2'd2;

   // Reset values: the threshold is 0.1 of the full 16-bit range, rounded.
   localparam logic [COUNT_W-1:0]      PARTICLE_COUNT_RESET = 8'd0;
   localparam logic [THRESHOLD_W-1:0]  HOP_THRESHOLD_RESET  = 17'd6554;
   localparam logic [SITE_FIELD_W-1:0] CHECK_SITE_RESET     = 7'd10;

   // Largest particle count that takes effect, and the flux ceiling.
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_PARTICLES);
   localparam logic [FLUX_W-1:0]  FLUX_MAX    = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PLACE   = 2'd0,
      FUNC_ATTEMPT = 2'd1,
      FUNC_CLEAR   = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 3'd0,
      ST_RETRY   = 3'd1,
      ST_BLOCKED = 3'd2,
      ST_STAYED  = 3'd3,
      ST_HOPPED  = 3'd4,
      ST_INVALID = 3'd5
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic [PIDX_W-1:0]        particle_index;
      logic [SITE_FIELD_W-1:0]  site;
      logic [RANDOM_W-1:0]      random_value;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic                     sweep_done;
      logic [FLUX_W-1:0]        flux_count;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]       particle_count;
      logic [THRESHOLD_W-1:0]   hop_threshold;
      logic [SITE_FIELD_W-1:0]  check_site;
   } cfg_type;

endpackage

@@ rtl/rehs_site_ram.sv @@
// ----------------------------------------------------------------------------
// Particle site memory
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module rehs_site_ram #(
   parameter int DATA_W = 7
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [rehs_pkg::PIDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0]            rd_data_ff,
   input  logic                         wr_en,
   input  logic [rehs_pkg::PIDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0]            wr_data
);

   logic [DATA_W-1:0] site_mem_ff [rehs_pkg::MAX_PARTICLES];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         site_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, bypassing a write to the same entry in this cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= site_mem_ff[rd_addr];
         end
      end
   end

endmodule

@@ rtl/rehs_ring_state.sv @@
// ----------------------------------------------------------------------------
// Ring state and step logic
// Holds the occupancy of the ring, the update marks, the sweep attempt count
// and the flux counter, and works out one item's result and state change.
// ----------------------------------------------------------------------------
module rehs_ring_state #(
   parameter int RING_SITES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            commit,
   input  rehs_pkg::req_type               item,
   input  rehs_pkg::cfg_type               cfg,
   input  logic [$clog2(RING_SITES)-1:0]   site_rd,
   output rehs_pkg::rsp_type               result,
   output logic                            site_wr_en,
   output logic [$clog2(RING_SITES)-1:0]   site_wr_data
);

   localparam int SITE_W = $clog2(RING_SITES);
   localparam int CMP_W  =
      ((SITE_W > rehs_pkg::SITE_FIELD_W) ? SITE_W : rehs_pkg::SITE_FIELD_W) + 1;
   localparam logic [SITE_W-1:0] LAST_SITE = SITE_W'(RING_SITES - 1);
   localparam logic [CMP_W-1:0]  SITES_CMP = CMP_W'(RING_SITES);

   logic [RING_SITES-1:0]                  occ_ff, occ_in;
   logic [rehs_pkg::MAX_PARTICLES-1:0]     mark_ff, mark_in;
   logic [rehs_pkg::COUNT_W-1:0]           attempt_ff, attempt_in;
   logic [rehs_pkg::FLUX_W-1:0]            flux_ff, flux_in;

   logic [rehs_pkg::COUNT_W-1:0]           count_eff;
   logic                                   idx_ok;
   logic                                   site_fits;
   logic [SITE_W-1:0]                      place_idx;
   logic [SITE_W-1:0]                      nxt;
   logic                                   at_check;
   logic                                   hop_go;
   logic [rehs_pkg::COUNT_W:0]             attempt_next;
   logic                                   sweep_end;

   // Operand preparation for this item.
   always_comb begin
      count_eff    = (cfg.particle_count > rehs_pkg::COUNT_LIMIT) ?
                     rehs_pkg::COUNT_LIMIT : cfg.particle_count;
      idx_ok       = {1'b0, item.particle_index} < count_eff;
      site_fits    = CMP_W'(item.site) < SITES_CMP;
      place_idx    = SITE_W'(item.site);
      nxt          = (site_rd == LAST_SITE) ? '0 : site_rd + 1'b1;
      at_check     = CMP_W'(site_rd) == CMP_W'(cfg.check_site);
      hop_go       = {1'b0, item.random_value} < cfg.hop_threshold;
      attempt_next = {1'b0, attempt_ff} + 1'b1;
      sweep_end    = attempt_next >= {1'b0, count_eff};
   end

   // Step decode: result and next state.
   always_comb begin
      occ_in            = occ_ff;
      mark_in           = mark_ff;
      attempt_in        = attempt_ff;
      flux_in           = flux_ff;
      result.status     = rehs_pkg::ST_INVALID;
      result.sweep_done = 1'b0;
      site_wr_en        = 1'b0;
      site_wr_data      = place_idx;

      unique case (item.func)
         rehs_pkg::FUNC_PLACE: begin
            if (site_fits && !occ_ff[place_idx]) begin
               occ_in[place_idx] = 1'b1;
               site_wr_en        = 1'b1;
               result.status     = rehs_pkg::ST_DONE;
            end
         end
         rehs_pkg::FUNC_ATTEMPT: begin
            if (idx_ok) begin
               if (mark_ff[item.particle_index]) begin
                  result.status = rehs_pkg::ST_RETRY;
               end else begin
                  if (occ_ff[nxt]) begin
                     result.status = rehs_pkg::ST_BLOCKED;
                  end else begin
                     if (hop_go) begin
                        occ_in[site_rd] = 1'b0;
                        occ_in[nxt]     = 1'b1;
                        site_wr_en      = 1'b1;
                        site_wr_data    = nxt;
                        if (at_check && (flux_ff != rehs_pkg::FLUX_MAX)) begin
                           flux_in = flux_ff + 1'b1;
                        end
                        result.status = rehs_pkg::ST_HOPPED;
                     end else begin
                        result.status = rehs_pkg::ST_STAYED;
                     end
                     mark_in[item.particle_index] = 1'b1;
                  end
                  // A counted attempt; the last one of a sweep clears the marks.
                  if (sweep_end) begin
                     mark_in           = '0;
                     attempt_in        = '0;
                     result.sweep_done = 1'b1;
                  end else begin
                     attempt_in = attempt_next[rehs_pkg::COUNT_W-1:0];
                  end
               end
            end
         end
         rehs_pkg::FUNC_CLEAR: begin
            occ_in        = '0;
            mark_in       = '0;
            attempt_in    = '0;
            flux_in       = '0;
            result.status = rehs_pkg::ST_DONE;
         end
         default: begin
            result.status = rehs_pkg::ST_INVALID;
         end
      endcase

      result.flux_count = flux_in;
   end

   // State registers, updated as the item moves on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         mark_ff    <= '0;
         attempt_ff <= '0;
         flux_ff    <= '0;
      end else if (commit) begin
         occ_ff     <= occ_in;
         mark_ff    <= mark_in;
         attempt_ff <= attempt_in;
         flux_ff    <= flux_in;
      end
   end

endmodule

@@ rtl/ring_exclusion_hop_step.sv @@
// The block takes one item per clock cycle and passes it through the input
// register, where the particle site is read from its memory, and then the
// result register, from which its result is returned. The ring
// occupancy, update marks, attempt count and flux counter are updated in the
// same cycle as the step logic, so each item sees every earlier item's effect
// and back-to-back items need no stall. The input side only stalls while the
// result register holds a result that has not been taken.
// ----------------------------------------------------------------------------
// Ring exclusion hop step
// Top level: transfer handshakes, configuration registers, input and result
// registers around the ring state and the particle site memory.
// ----------------------------------------------------------------------------
module ring_exclusion_hop_step #(
   parameter int RING_SITES = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rehs_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rehs_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [rehs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rehs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int SITE_W = $clog2(RING_SITES);

   rehs_pkg::cfg_type   cfg_ff;
   logic                x_valid_ff, x_valid_in;
   rehs_pkg::req_type   x_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rehs_pkg::rsp_type   rsp_data_ff;
   rehs_pkg::rsp_type   step_result;
   logic                accept;
   logic                advance;
   logic [SITE_W-1:0]   site_rd;
   logic                site_wr_en;
   logic [SITE_W-1:0]   site_wr_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.particle_count <= rehs_pkg::PARTICLE_COUNT_RESET;
         cfg_ff.hop_threshold  <= rehs_pkg::HOP_THRESHOLD_RESET;
         cfg_ff.check_site     <= rehs_pkg::CHECK_SITE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rehs_pkg::CSR_PARTICLE_COUNT:
               cfg_ff.particle_count <= csr_wdata[rehs_pkg::COUNT_W-1:0];
            rehs_pkg::CSR_HOP_THRESHOLD:
               cfg_ff.hop_threshold  <= csr_wdata;
            rehs_pkg::CSR_CHECK_SITE:
               cfg_ff.check_site     <= csr_wdata[rehs_pkg::SITE_FIELD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake control: the item in the input register moves on whenever
   // the result register is empty or its result is being transferred out.
   always_comb begin
      advance      = x_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !x_valid_ff || advance;
      accept       = req_valid && req_ready;
      x_valid_in   = accept || (x_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Particle site memory, read as an item is transferred in.
   rehs_site_ram #(
      .DATA_W     (SITE_W)
   ) u_site_ram (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (req_data.particle_index),
      .rd_data_ff (site_rd),
      .wr_en      (site_wr_en && advance),
      .wr_addr    (x_data_ff.particle_index),
      .wr_data    (site_wr_data)
   );

   // Ring state and step logic.
   rehs_ring_state #(
      .RING_SITES   (RING_SITES)
   ) u_ring_state (
      .clock        (clock),
      .reset        (reset),
      .commit       (advance),
      .item         (x_data_ff),
      .cfg          (cfg_ff),
      .site_rd      (site_rd),
      .result       (step_result),
      .site_wr_en   (site_wr_en),
      .site_wr_data (site_wr_data)
   );

endmodule
